@@ hw/rtl/pwls_pkg.sv @@
// Shared widths, register indexes and stage payload types for the PID core.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package pwls_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;
   localparam int ERR_W      = DATA_WIDTH + 1;
   localparam int DIF_W      = ERR_W + 1;
   localparam int ACC_W      = 32;
   localparam int CNT_W      = 17;
   localparam int P_W        = DATA_WIDTH + ERR_W;
   localparam int I_W        = DATA_WIDTH + ACC_W;
   localparam int D_W        = DATA_WIDTH + DIF_W;
   localparam int SUM_W      = I_W + 1;
   localparam int SHF_W      = SUM_W - FRAC_BITS;
   localparam int DRV_W      = SHF_W + 1;
   localparam int CSR_IDX_W  = 4;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP             = 4'd0,
      CSR_KI             = 4'd1,
      CSR_KD             = 4'd2,
      CSR_FEEDFORWARD    = 4'd3,
      CSR_DRIVE_FLOOR    = 4'd4,
      CSR_DRIVE_CEILING  = 4'd5,
      CSR_DEADBAND       = 4'd6,
      CSR_SETTLE_SAMPLES = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] kp;
      logic signed [DATA_WIDTH-1:0] ki;
      logic signed [DATA_WIDTH-1:0] kd;
      logic signed [DATA_WIDTH-1:0] feedforward;
      logic signed [DATA_WIDTH-1:0] drive_floor;
      logic signed [DATA_WIDTH-1:0] drive_ceiling;
      logic        [DATA_WIDTH-1:0] deadband;
      logic        [DATA_WIDTH-1:0] settle_samples;
   } cfg_type;

   // Error stage payload
   typedef struct packed {
      logic signed [ERR_W-1:0] err;
      logic signed [ACC_W-1:0] integ;
      logic signed [DIF_W-1:0] delta;
      logic                    on_target;
   } front_type;

   // Product stage payload
   typedef struct packed {
      logic signed [P_W-1:0] p_term;
      logic signed [I_W-1:0] i_term;
      logic signed [D_W-1:0] d_term;
      logic                  on_target;
   } prod_type;

   // Scaled sum stage payload
   typedef struct packed {
      logic signed [SHF_W-1:0] scaled;
      logic                    on_target;
   } sum_type;

   // Load strobes for the multiply-accumulate stages
   typedef struct packed {
      logic load_prod;
      logic load_sum;
   } stage_ctrl_type;

endpackage

`default_nettype wire

@@ hw/rtl/pwls_csr.sv @@
// Configuration register file for the PID core.
// Depends on pwls_pkg for the register indexes and cfg_type.
`default_nettype none

module pwls_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               wr_en,
   input  wire logic [pwls_pkg::CSR_IDX_W-1:0]     wr_index,
   input  wire logic [pwls_pkg::DATA_WIDTH-1:0]    wr_data,
   output pwls_pkg::cfg_type                       cfg
);

   pwls_pkg::cfg_type cfg_ff;
   pwls_pkg::cfg_type cfg_in;

   // Decode the register index; drop writes beyond the list
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            pwls_pkg::CSR_KP:             cfg_in.kp             = wr_data;
            pwls_pkg::CSR_KI:             cfg_in.ki             = wr_data;
            pwls_pkg::CSR_KD:             cfg_in.kd             = wr_data;
            pwls_pkg::CSR_FEEDFORWARD:    cfg_in.feedforward    = wr_data;
            pwls_pkg::CSR_DRIVE_FLOOR:    cfg_in.drive_floor    = wr_data;
            pwls_pkg::CSR_DRIVE_CEILING:  cfg_in.drive_ceiling  = wr_data;
            pwls_pkg::CSR_DEADBAND:       cfg_in.deadband       = wr_data;
            pwls_pkg::CSR_SETTLE_SAMPLES: cfg_in.settle_samples = wr_data;
            default:                      cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pwls_front.sv @@
// Error stage: error, saturating integral, derivative difference and settle tracking.
// Holds the loop state; depends on pwls_pkg.
`default_nettype none

module pwls_front (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   accept,
   input  wire logic signed [pwls_pkg::DATA_WIDTH-1:0] sensor,
   input  wire logic signed [pwls_pkg::DATA_WIDTH-1:0] setpoint,
   input  wire logic                                   restart,
   input  wire logic        [pwls_pkg::DATA_WIDTH-1:0] deadband,
   input  wire logic        [pwls_pkg::DATA_WIDTH-1:0] settle_samples,
   output pwls_pkg::front_type                         front_q
);

   localparam int EW = pwls_pkg::ERR_W;
   localparam int AW = pwls_pkg::ACC_W;

   logic signed [AW-1:0]          integ_ff, integ_in, integ_base;
   logic signed [EW-1:0]          prev_ff, prev_base;
   logic                          settling_ff, settling_in, settling_base;
   logic [pwls_pkg::CNT_W-1:0]    count_ff, count_in, count_base;
   pwls_pkg::front_type           front_ff, front_in;

   logic signed [EW-1:0]          err;
   logic [AW:0]                   isum;
   logic [EW-1:0]                 mag;
   logic                          in_band;

   // Form error, integral, difference and settle state for this sample
   always_comb begin
      integ_base    = restart ? '0   : integ_ff;
      prev_base     = restart ? '0   : prev_ff;
      settling_base = restart ? 1'b0 : settling_ff;
      count_base    = restart ? '0   : count_ff;

      err  = {setpoint[pwls_pkg::DATA_WIDTH-1], setpoint}
           - {sensor[pwls_pkg::DATA_WIDTH-1], sensor};
      isum = {integ_base[AW-1], integ_base} + {{(AW + 1 - EW){err[EW-1]}}, err};
      if (isum[AW] != isum[AW-1]) begin
         integ_in = isum[AW] ? {1'b1, {(AW - 1){1'b0}}} : {1'b0, {(AW - 1){1'b1}}};
      end else begin
         integ_in = isum[AW-1:0];
      end

      mag     = err[EW-1] ? (~err + 1'b1) : err;
      in_band = mag < {1'b0, deadband};

      front_in.err       = err;
      front_in.integ     = integ_in;
      front_in.delta     = {err[EW-1], err} - {prev_base[EW-1], prev_base};
      front_in.on_target = 1'b0;
      settling_in        = 1'b0;
      count_in           = '0;
      if (in_band) begin
         settling_in = 1'b1;
         if (settling_base) begin
            count_in           = (count_base == pwls_pkg::CNT_MAX) ? count_base
                                                                   : count_base + 1'b1;
            front_in.on_target = count_in > {1'b0, settle_samples};
         end
      end
   end

   // Advance the loop state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         prev_ff     <= '0;
         settling_ff <= 1'b0;
         count_ff    <= '0;
      end else if (accept) begin
         integ_ff    <= integ_in;
         prev_ff     <= err;
         settling_ff <= settling_in;
         count_ff    <= count_in;
      end
   end

   // Hold the stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         front_ff <= front_in;
      end
   end

   assign front_q = front_ff;

   a_restart_integ: assert property (@(posedge clock) disable iff (reset)
      accept && restart |=>
         front_ff.integ == {{(AW - EW){front_ff.err[EW-1]}}, front_ff.err})
      else $error("integral after restart differs from the error");

   a_restart_delta: assert property (@(posedge clock) disable iff (reset)
      accept && restart |=> front_ff.delta == {front_ff.err[EW-1], front_ff.err})
      else $error("difference after restart differs from the error");

   a_zero_band: assert property (@(posedge clock) disable iff (reset)
      accept && deadband == '0 |=> !front_ff.on_target)
      else $error("on target flagged with a zero deadband");

endmodule

`default_nettype wire

@@ hw/rtl/pwls_mac.sv @@
// Multiply and accumulate stages: three gain products, then their scaled sum.
// Depends on pwls_pkg for the stage payload types.
`default_nettype none

module pwls_mac (
   input  wire logic                 clock,
   input  pwls_pkg::stage_ctrl_type  ctrl,
   input  pwls_pkg::cfg_type         cfg,
   input  pwls_pkg::front_type       front_q,
   output pwls_pkg::sum_type         sum_q
);

   localparam int SW = pwls_pkg::SUM_W;

   pwls_pkg::prod_type   prod_ff, prod_in;
   pwls_pkg::sum_type    sum_ff, sum_in;
   logic signed [SW-1:0] total;

   // Form the three products in parallel
   always_comb begin
      prod_in.p_term    = $signed(cfg.kp) * $signed(front_q.err);
      prod_in.i_term    = $signed(cfg.ki) * $signed(front_q.integ);
      prod_in.d_term    = $signed(cfg.kd) * $signed(front_q.delta);
      prod_in.on_target = front_q.on_target;
   end

   // Add the products and drop the fraction bits (floor)
   always_comb begin
      total = {{(SW - pwls_pkg::P_W){prod_ff.p_term[pwls_pkg::P_W-1]}}, prod_ff.p_term}
            + {{(SW - pwls_pkg::I_W){prod_ff.i_term[pwls_pkg::I_W-1]}}, prod_ff.i_term}
            + {{(SW - pwls_pkg::D_W){prod_ff.d_term[pwls_pkg::D_W-1]}}, prod_ff.d_term};
      sum_in.scaled    = total[SW-1:pwls_pkg::FRAC_BITS];
      sum_in.on_target = prod_ff.on_target;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         prod_ff <= prod_in;
      end
      if (ctrl.load_sum) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_q = sum_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pwls_out.sv @@
// Output stage: feedforward offset, saturation to the drive width and limit clamp.
// Depends on pwls_pkg for cfg_type and sum_type.
`default_nettype none

module pwls_out (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    load,
   input  pwls_pkg::cfg_type                            cfg,
   input  pwls_pkg::sum_type                            sum_q,
   output logic signed [pwls_pkg::DATA_WIDTH-1:0]       drive,
   output logic                                         on_target
);

   localparam int DW = pwls_pkg::DATA_WIDTH;
   localparam int RW = pwls_pkg::DRV_W;
   localparam int XW = pwls_pkg::SHF_W;

   logic signed [DW-1:0] drive_ff, drive_in, sat_val;
   logic                 on_target_ff;
   logic [RW-1:0]        total;
   logic [RW-DW:0]       high_bits;

   // Add the offset, saturate, then clamp when either limit is set
   always_comb begin
      total     = {{(RW - XW){sum_q.scaled[XW-1]}}, sum_q.scaled}
                + {{(RW - DW){cfg.feedforward[DW-1]}}, cfg.feedforward};
      high_bits = total[RW-1:DW-1];
      if ((&high_bits) || !(|high_bits)) begin
         sat_val = total[DW-1:0];
      end else begin
         sat_val = total[RW-1] ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
      end
      drive_in = sat_val;
      if (cfg.drive_floor != '0 || cfg.drive_ceiling != '0) begin
         if (sat_val < cfg.drive_floor) begin
            drive_in = cfg.drive_floor;
         end else if (sat_val > cfg.drive_ceiling) begin
            drive_in = cfg.drive_ceiling;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         drive_ff     <= drive_in;
         on_target_ff <= sum_q.on_target;
      end
   end

   assign drive     = drive_ff;
   assign on_target = on_target_ff;

   a_clamp_range: assert property (@(posedge clock) disable iff (reset)
      load && (cfg.drive_floor != '0 || cfg.drive_ceiling != '0)
           && cfg.drive_floor <= cfg.drive_ceiling |=>
         drive_ff >= $past(cfg.drive_floor) && drive_ff <= $past(cfg.drive_ceiling))
      else $error("clamped drive outside the limits");

endmodule

`default_nettype wire

@@ hw/rtl/pid_with_limits_and_settle_core.sv @@
// PID controller with feedforward, output limits and settle detection: top level.
// Instantiates pwls_csr, pwls_front, pwls_mac and pwls_out; depends on pwls_pkg.
//
//   channel | direction | transfer when           | carries
//   req     | in        | req_tvalid & req_tready | tdata {setpoint, sensor}, tuser restart
//   rsp     | out       | rsp_tvalid & rsp_tready | tdata drive, tuser on_target
//   csr     | in        | csr_valid & csr_ready   | csr_index, csr_data (always ready)
//
// One sample is taken per cycle while the result side is not stalled; its result is
// presented once it has passed the error, product, sum and output registers.
// Loop state (integral, last error, settle count) updates in the error stage, so a
// new sample can follow in the very next cycle.
// Each stage moves on when the one after it is empty or moving, so a stalled result
// lets earlier stages fill; up to four samples are held in flight.
// Reset clears the gains, limits, loop state and all stage valid flags.
`default_nettype none

module pid_with_limits_and_settle_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // slave side
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [2*pwls_pkg::DATA_WIDTH-1:0]   req_tdata,  // [15:0] sensor, [31:16] setpoint
   input  wire logic                                req_tuser,  // [0] restart
   // master side
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [pwls_pkg::DATA_WIDTH-1:0]          rsp_tdata,  // [15:0] drive
   output logic                                     rsp_tuser,  // [0] on_target
   // configuration writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pwls_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pwls_pkg::DATA_WIDTH-1:0]     csr_data
);

   localparam int DW = pwls_pkg::DATA_WIDTH;

   pwls_pkg::cfg_type        cfg;
   pwls_pkg::front_type      front_q;
   pwls_pkg::sum_type        sum_q;
   pwls_pkg::stage_ctrl_type mac_ctrl;

   logic front_vld_ff, prod_vld_ff, sum_vld_ff, rsp_vld_ff;
   logic take_front, take_prod, take_sum, take_rsp;
   logic accept;
   logic signed [DW-1:0] drive;
   logic on_target;

   // Each stage may load when it is empty or its contents move on
   always_comb begin
      take_rsp   = !rsp_vld_ff || rsp_tready;
      take_sum   = !sum_vld_ff || take_rsp;
      take_prod  = !prod_vld_ff || take_sum;
      take_front = !front_vld_ff || take_prod;
      accept     = req_tvalid && take_front;
      mac_ctrl.load_prod = take_prod && front_vld_ff;
      mac_ctrl.load_sum  = take_sum && prod_vld_ff;
   end

   // Advance the stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= 1'b0;
         prod_vld_ff  <= 1'b0;
         sum_vld_ff   <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         if (take_front) front_vld_ff <= req_tvalid;
         if (take_prod)  prod_vld_ff  <= front_vld_ff;
         if (take_sum)   sum_vld_ff   <= prod_vld_ff;
         if (take_rsp)   rsp_vld_ff   <= sum_vld_ff;
      end
   end

   pwls_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   pwls_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .sensor         (req_tdata[DW-1:0]),
      .setpoint       (req_tdata[2*DW-1:DW]),
      .restart        (req_tuser),
      .deadband       (cfg.deadband),
      .settle_samples (cfg.settle_samples),
      .front_q        (front_q)
   );

   pwls_mac u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .cfg     (cfg),
      .front_q (front_q),
      .sum_q   (sum_q)
   );

   pwls_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (take_rsp && sum_vld_ff),
      .cfg       (cfg),
      .sum_q     (sum_q),
      .drive     (drive),
      .on_target (on_target)
   );

   assign req_tready = take_front;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = drive;
   assign rsp_tuser  = on_target;
   assign csr_ready  = 1'b1;

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      front_vld_ff && prod_vld_ff && sum_vld_ff && rsp_vld_ff && !rsp_tready
         |-> !req_tready)
      else $error("sample taken while every stage is stalled");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_tready && !sum_vld_ff |=> !rsp_tvalid)
      else $error("result repeated after its transfer");

endmodule

`default_nettype wire

@@ tb/pwls_tb_pkg.sv @@
// Scoreboard for the PID core testbench: a bit-exact loop predictor and a queue of
// expected drive results. Depends on pwls_pkg for widths, register indexes and cfg_type.
package pwls_tb_pkg;

   typedef struct {
      logic signed [pwls_pkg::DATA_WIDTH-1:0] drive;
      logic                                   on_target;
   } drive_result_type;

   class drive_scoreboard;
      pwls_pkg::cfg_type                 cfg;
      logic signed [pwls_pkg::ACC_W-1:0] integral;
      logic signed [pwls_pkg::ERR_W-1:0] last_err;
      logic                              settling;
      logic [pwls_pkg::CNT_W-1:0]        settle_count;
      drive_result_type                  expected_drive[$];
      int unsigned                       mismatches;

      function new();
         cfg = '0;
         mismatches = 0;
         clear_loop();
      endfunction

      function void clear_loop();
         integral = '0;
         last_err = '0;
         settling = 1'b0;
         settle_count = '0;
      endfunction

      function int pending();
         return expected_drive.size();
      endfunction

      // Mirror a register transfer; indexes past the register file are dropped
      function void write_register(logic [pwls_pkg::CSR_IDX_W-1:0] index,
                                   logic [pwls_pkg::DATA_WIDTH-1:0] value);
         case (index)
            pwls_pkg::CSR_KP:             cfg.kp = value;
            pwls_pkg::CSR_KI:             cfg.ki = value;
            pwls_pkg::CSR_KD:             cfg.kd = value;
            pwls_pkg::CSR_FEEDFORWARD:    cfg.feedforward = value;
            pwls_pkg::CSR_DRIVE_FLOOR:    cfg.drive_floor = value;
            pwls_pkg::CSR_DRIVE_CEILING:  cfg.drive_ceiling = value;
            pwls_pkg::CSR_DEADBAND:       cfg.deadband = value;
            pwls_pkg::CSR_SETTLE_SAMPLES: cfg.settle_samples = value;
            default: ;
         endcase
      endfunction

      // Advance the loop by one accepted sample and queue the drive it must produce
      function void note_sample(logic signed [pwls_pkg::DATA_WIDTH-1:0] sensor,
                                logic signed [pwls_pkg::DATA_WIDTH-1:0] setpoint,
                                logic restart);
         longint           err, acc, sum, drv, mag, lower, upper;
         longint           acc_hi, drv_hi;
         drive_result_type res;
         acc_hi = (longint'(1) << (pwls_pkg::ACC_W - 1)) - 1;
         drv_hi = (longint'(1) << (pwls_pkg::DATA_WIDTH - 1)) - 1;
         if (restart)
            clear_loop();

         err = longint'(setpoint) - longint'(sensor);
         acc = longint'(integral) + err;
         if (acc > acc_hi)
            acc = acc_hi;
         else if (acc < -acc_hi - 1)
            acc = -acc_hi - 1;
         integral = acc[pwls_pkg::ACC_W-1:0];

         sum = longint'($signed(cfg.kp)) * err + longint'($signed(cfg.ki)) * acc
             + longint'($signed(cfg.kd)) * (err - longint'(last_err));
         drv = (sum >>> pwls_pkg::FRAC_BITS) + longint'($signed(cfg.feedforward));
         if (drv > drv_hi)
            drv = drv_hi;
         else if (drv < -drv_hi - 1)
            drv = -drv_hi - 1;

         // Clamp only while at least one limit is set; when inverted, below floor takes the floor, else ceiling
         lower = longint'($signed(cfg.drive_floor));
         upper = longint'($signed(cfg.drive_ceiling));
         if (lower != 0 || upper != 0) begin
            if (drv < lower)
               drv = lower;
            else if (drv > upper)
               drv = upper;
         end
         last_err = err[pwls_pkg::ERR_W-1:0];

         // Settle tracking: first in-band sample only arms the counter
         res.on_target = 1'b0;
         mag = (err < 0) ? -err : err;
         if (mag < longint'(cfg.deadband)) begin
            if (!settling) begin
               settling = 1'b1;
               settle_count = '0;
            end else begin
               if (settle_count != pwls_pkg::CNT_MAX)
                  settle_count = settle_count + 1'b1;
               res.on_target = (settle_count > cfg.settle_samples);
            end
         end else begin
            settling = 1'b0;
            settle_count = '0;
         end

         res.drive = drv[pwls_pkg::DATA_WIDTH-1:0];
         expected_drive.push_back(res);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] check failed: %0s", $time, msg);
         mismatches++;
      endtask

      // Compare one result transfer against the oldest queued drive
      task check_result(logic [pwls_pkg::DATA_WIDTH-1:0] drive, logic on_target);
         drive_result_type exp;
         if (expected_drive.size() == 0) begin
            report_mismatch($sformatf("unexpected result drive %0d on_target %0b",
                                      $signed(drive), on_target));
            return;
         end
         exp = expected_drive.pop_front();
         if (drive !== exp.drive)
            report_mismatch($sformatf("drive got %0d expected %0d",
                                      $signed(drive), exp.drive));
         if (on_target !== exp.on_target)
            report_mismatch($sformatf("on_target got %0b expected %0b",
                                      on_target, exp.on_target));
      endtask
   endclass

endpackage

@@ tb/tb_pid_with_limits_and_settle_core.sv @@
// Testbench top for pid_with_limits_and_settle_core: directed, saturation and random
// phases with random stalls on both streams. Depends on pwls_pkg and pwls_tb_pkg.
module tb_pid_with_limits_and_settle_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW           = pwls_pkg::DATA_WIDTH;
   localparam int IDX_W        = pwls_pkg::CSR_IDX_W;
   localparam int NUM_CSR      = 8;
   localparam int RUN_LIMIT    = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int LONG_HOLD    = 200;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS  = 90;
   localparam logic signed [DW-1:0] S_MAX = 16'sh7fff;
   localparam logic signed [DW-1:0] S_MIN = 16'sh8000;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [2*DW-1:0]             req_tdata;   // [15:0] sensor, [31:16] setpoint
   logic                        req_tuser;   // [0] restart
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [DW-1:0]               rsp_tdata;   // [15:0] drive
   logic                        rsp_tuser;   // [0] on_target
   logic                        csr_valid;
   logic                        csr_ready;
   logic [IDX_W-1:0]            csr_index;
   logic [DW-1:0]               csr_data;

   pwls_tb_pkg::drive_scoreboard loop_sb;
   bit              steady;
   bit              hold_rsp_req;
   int unsigned     cycle_count = 0;

   pid_with_limits_and_settle_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one; none while steady
   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Result side: random back-pressure, plus one long hold on request
   initial begin
      int stall_left;
      int gap;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            loop_sb.check_result(rsp_tdata, rsp_tuser);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            stall_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else begin
            gap = pick_gap();
            if (gap == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               stall_left = gap - 1;
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   // Hold a register write until the transfer; valid is dropped by the caller
   task automatic write_csr(input logic [IDX_W-1:0] index,
                            input logic [DW-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      loop_sb.write_register(index, value);
   endtask

   task automatic configure(input pwls_pkg::cfg_type c);
      int unsigned spare_index;
      int unsigned spare_data;
      spare_index = $urandom_range(NUM_CSR, (1 << IDX_W) - 1);
      spare_data  = $urandom;
      write_csr(pwls_pkg::CSR_KP, c.kp);
      write_csr(pwls_pkg::CSR_KI, c.ki);
      write_csr(pwls_pkg::CSR_KD, c.kd);
      write_csr(pwls_pkg::CSR_FEEDFORWARD, c.feedforward);
      write_csr(pwls_pkg::CSR_DRIVE_FLOOR, c.drive_floor);
      write_csr(pwls_pkg::CSR_DRIVE_CEILING, c.drive_ceiling);
      write_csr(pwls_pkg::CSR_DEADBAND, c.deadband);
      write_csr(pwls_pkg::CSR_SETTLE_SAMPLES, c.settle_samples);
      // an index past the register file must leave everything alone
      write_csr(spare_index[IDX_W-1:0], spare_data[DW-1:0]);
      csr_valid <= 1'b0;
   endtask

   task automatic send_sample(input logic signed [DW-1:0] sensor,
                              input logic signed [DW-1:0] setpoint,
                              input logic restart);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {setpoint, sensor};
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
      loop_sb.note_sample(sensor, setpoint, restart);
   endtask

   // Stop offering and wait for every queued drive to come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (loop_sb.pending() != 0)
         @(posedge clock);
   endtask

   function automatic pwls_pkg::cfg_type random_cfg();
      pwls_pkg::cfg_type c;
      if ($urandom_range(0, 1) == 0) begin
         c.kp = 16'(int'($urandom_range(0, 2048)) - 1024);
         c.ki = 16'(int'($urandom_range(0, 64)) - 32);
         c.kd = 16'(int'($urandom_range(0, 2048)) - 1024);
      end else begin
         c.kp = 16'($urandom);
         c.ki = 16'($urandom);
         c.kd = 16'($urandom);
      end
      c.feedforward = 16'(int'($urandom_range(0, 4000)) - 2000);
      c.drive_floor = $urandom_range(0, 3) == 0 ? 16'sd0
                                                : -$signed(16'($urandom_range(0, 20000)));
      c.drive_ceiling = $urandom_range(0, 3) == 0 ? 16'sd0
                                                  : $signed(16'($urandom_range(0, 20000)));
      c.deadband = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2000));
      c.settle_samples = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8));
      return c;
   endfunction

   task automatic directed_part();
      pwls_pkg::cfg_type c;
      c = '0;
      c.kp = 16'sd256;
      c.ki = 16'sd16;
      c.kd = 16'sd128;
      c.drive_floor = -16'sd1000;
      c.drive_ceiling = 16'sd1000;
      c.deadband = 16'd4;
      c.settle_samples = 16'd2;
      configure(c);
      // settle from a restart, then walk in and out of the band at its edges
      send_sample(16'sd5, 16'sd5, 1'b1);
      repeat (4) send_sample(16'sd5, 16'sd5, 1'b0);
      send_sample(16'sd0, 16'sd3, 1'b0);
      send_sample(16'sd0, 16'sd4, 1'b0);
      send_sample(16'sd3, 16'sd0, 1'b0);
      send_sample(16'sd4, 16'sd0, 1'b0);
      // largest errors either way, clamped to the limits
      send_sample(S_MIN, S_MAX, 1'b0);
      send_sample(S_MAX, S_MIN, 1'b0);
      send_sample(16'sd1000, 16'sd1100, 1'b1);
      wait_for_results();

      // no limits: drive saturates at both ends
      c.kp = S_MAX;
      c.ki = '0;
      c.kd = S_MAX;
      c.feedforward = S_MIN;
      c.drive_floor = '0;
      c.drive_ceiling = '0;
      configure(c);
      send_sample(S_MIN, S_MAX, 1'b1);
      send_sample(S_MAX, S_MIN, 1'b0);
      send_sample(16'sd0, 16'sd0, 1'b0);
      wait_for_results();

      // inverted limits and a zero deadband
      c.kp = 16'sd256;
      c.kd = '0;
      c.feedforward = '0;
      c.drive_floor = 16'sd50;
      c.drive_ceiling = -16'sd50;
      c.deadband = '0;
      configure(c);
      send_sample(16'sd0, 16'sd1000, 1'b1);
      send_sample(16'sd1000, 16'sd0, 1'b0);
      send_sample(16'sd0, 16'sd0, 1'b0);
      wait_for_results();
   endtask

   // Long in-band run: the integral swings the drive into saturation both ways
   // while the settle flag comes up and stays up
   task automatic saturation_run();
      pwls_pkg::cfg_type c;
      c = '0;
      c.ki = 16'sd16;
      c.deadband = 16'hffff;
      c.settle_samples = 16'd20;
      configure(c);
      steady = 1'b1;
      send_sample(S_MIN, S_MAX - 16'sd1, 1'b1);
      repeat (15) send_sample(S_MIN, S_MAX - 16'sd1, 1'b0);
      repeat (30) send_sample(S_MAX - 16'sd1, S_MIN, 1'b0);
      repeat (15) send_sample(S_MIN, S_MAX - 16'sd1, 1'b0);
      wait_for_results();
      steady = 1'b0;
   endtask

   task automatic random_part();
      pwls_pkg::cfg_type c;
      int      mode;
      int      band;
      int      target;
      logic signed [DW-1:0] sensor;
      logic signed [DW-1:0] setpoint;
      mode = 0;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_for_results();
         if (ph == 0) begin
            c.kp = S_MIN;
            c.ki = S_MAX;
            c.kd = S_MIN;
            c.feedforward = S_MAX;
            c.drive_floor = S_MIN;
            c.drive_ceiling = S_MAX;
            c.deadband = 16'hffff;
            c.settle_samples = 16'hffff;
         end else if (ph == 1) begin
            c.kp = S_MAX;
            c.ki = S_MIN;
            c.kd = S_MAX;
            c.feedforward = S_MIN;
            c.drive_floor = '0;
            c.drive_ceiling = '0;
            c.deadband = '0;
            c.settle_samples = '0;
         end else begin
            c = random_cfg();
         end
         configure(c);
         steady = (ph == 2 || ph == 4);
         // long result hold while samples keep coming: the pipeline backs up
         if (ph == 2)
            hold_rsp_req = 1'b1;
         band = int'(c.deadband) + 2;
         if (band > 3000)
            band = 3000;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 7) == 0)
               mode = $urandom_range(0, 9);
            sensor = 16'($urandom);
            if (mode < 6) begin
               target = int'(sensor) + int'($urandom_range(0, 2 * band)) - band;
               if (target > int'(S_MAX))
                  target = S_MAX;
               else if (target < int'(S_MIN))
                  target = S_MIN;
               setpoint = 16'(target);
            end else if (mode < 9) begin
               setpoint = 16'($urandom);
            end else begin
               sensor = $urandom_range(0, 1) ? S_MAX : S_MIN;
               setpoint = $urandom_range(0, 1) ? S_MAX : S_MIN;
            end
            send_sample(sensor, setpoint, $urandom_range(0, 19) == 0);
            if ($urandom_range(0, 49) == 0)
               wait_for_results();
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      rsp_tready <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      steady = 1'b0;
      hold_rsp_req = 1'b0;
      loop_sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_part();
      saturation_run();
      random_part();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (loop_sb.mismatches == 0 && loop_sb.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
